@@ hw/rtl/wmr_pkg.sv @@
`default_nettype none
package wmr_pkg;

	localparam int VOLUME_W  = 32;
	localparam int Q_BITS    = 16;
	localparam int RATIO_W   = 18;
	localparam int STEP_W    = 5;
	localparam logic [RATIO_W-1:0] RATIO_MAX = RATIO_W'(131072);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INS_RD,
		ST_INS_CMP,
		ST_MED_A,
		ST_MED_B,
		ST_MED_C,
		ST_CALC,
		ST_FIN
	} wmr_state_t;

	typedef enum logic [1:0] {
		DV_IDLE,
		DV_MUL,
		DV_DIV
	} wmr_dv_state_t;

endpackage
`default_nettype wire

@@ hw/rtl/wmr_if.sv @@
`default_nettype none
interface wmr_smp_if;
	logic                         valid;
	logic                         ready;
	logic [wmr_pkg::VOLUME_W-1:0] volume;
	logic                         missing;
	logic                         last;
	modport source (output valid, volume, missing, last, input ready);
	modport sink   (input valid, volume, missing, last, output ready);
endinterface

interface wmr_res_if;
	logic                        valid;
	logic                        ready;
	logic [wmr_pkg::RATIO_W-1:0] ratio;
	logic                        empty_res;
	logic                        overflowed;
	modport source (output valid, ratio, empty_res, overflowed, input ready);
	modport sink   (input valid, ratio, empty_res, overflowed, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/wmr_ram.sv @@
`default_nettype none
module wmr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

@@ hw/rtl/wmr_div.sv @@
`default_nettype none
// twice_med * cnt by shift-add, then restoring division against 2*sum
module wmr_div #(
	parameter int SB = 32,
	parameter int CW = 9
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [SB:0]                   twice_med,
	input  wire logic [CW-1:0]                 cnt,
	input  wire logic [SB+CW-1:0]              sum,
	output logic                               done,
	output logic      [wmr_pkg::RATIO_W-1:0]   ratio
);
	import wmr_pkg::*;

	localparam int NUMW = SB + 1 + CW;
	localparam int SUMW = SB + CW;
	localparam int RW   = SUMW + 2;

	wmr_dv_state_t     state_q, state_d;
	logic [SB:0]       tm_q;
	logic [CW-1:0]     cnt_sh_q;
	logic [SUMW:0]     den_q;
	logic [NUMW-1:0]   acc_q, acc_d;
	logic [RW-1:0]     r_q;
	logic [RW:0]       trial;
	logic              ge;
	logic [RATIO_W-1:0] nl_q, q_q;
	logic [STEP_W-1:0] idx_q;
	logic              done_q;
	logic              mul_en, div_en;

	always_comb begin
		state_d = state_q;
		case (state_q)
			DV_IDLE: if (start) state_d = DV_MUL;
			DV_MUL:  if (idx_q == '0) state_d = DV_DIV;
			DV_DIV:  if (idx_q == '0) state_d = DV_IDLE;
			default: state_d = DV_IDLE;
		endcase
	end

	always_comb begin
		mul_en = 1'b0;
		div_en = 1'b0;
		case (state_q)
			DV_MUL:  mul_en = 1'b1;
			DV_DIV:  div_en = 1'b1;
			default: ;
		endcase
	end

	assign acc_d = {acc_q[NUMW-2:0], 1'b0} + (cnt_sh_q[CW-1] ? NUMW'(tm_q) : '0);
	assign trial = {r_q, nl_q[RATIO_W-1]};
	assign ge    = trial >= (RW+1)'(den_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DV_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= div_en && (idx_q == '0);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == DV_IDLE && start) begin
			tm_q     <= twice_med;
			cnt_sh_q <= cnt;
			den_q    <= {sum, 1'b0};
			acc_q    <= '0;
			idx_q    <= STEP_W'(CW - 1);
		end else if (mul_en) begin
			acc_q    <= acc_d;
			cnt_sh_q <= cnt_sh_q << 1;
			if (idx_q == '0) begin
				// numerator << 16: top part seeds the remainder
				r_q   <= RW'(acc_d >> 2);
				nl_q  <= {acc_d[1:0], {Q_BITS{1'b0}}};
				q_q   <= '0;
				idx_q <= STEP_W'(RATIO_W - 1);
			end else begin
				idx_q <= idx_q - 1'b1;
			end
		end else if (div_en) begin
			r_q   <= ge ? RW'(trial - (RW+1)'(den_q)) : RW'(trial);
			q_q   <= {q_q[RATIO_W-2:0], ge};
			nl_q  <= nl_q << 1;
			idx_q <= idx_q - 1'b1;
		end
	end

	assign done  = done_q;
	assign ratio = (q_q > RATIO_MAX) ? RATIO_MAX : q_q;
endmodule
`default_nettype wire

@@ hw/rtl/window_median_to_mean_ratio.sv @@
// channel | dir | payload                          | transaction
// smp     | in  | volume, missing, last            | valid && ready
// res     | out | ratio, empty_res, overflowed     | valid && ready
// a sample that is not kept is taken in ST_IDLE alone; a kept one then runs ST_INS_RD, plus
// ST_INS_CMP and ST_INS_RD again per entry shifted by the insertion sort in the sample memory
// a last item then runs the median reads, the shift-add multiply and the 18-step divide
// (all skipped for an empty window), plus any wait for the output register
// reset clears count, sum and flags; the memory needs no clearing.
// a waiting result sits in the output register; the next window proceeds meanwhile.
`default_nettype none
module window_median_to_mean_ratio #(
	parameter int WINDOW_DEPTH = 256,
	parameter int SAMPLE_BITS  = 32
) (
	input wire logic clk,
	input wire logic arst_n,
	wmr_smp_if.sink  smp,
	wmr_res_if.source res
);
	import wmr_pkg::*;

	localparam int SB   = SAMPLE_BITS;
	localparam int CW   = $clog2(WINDOW_DEPTH + 1);
	localparam int AW   = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int MD   = 1 << AW;
	localparam int SUMW = SB + CW;

	wmr_state_t       state_q, state_d;
	logic [SB+VOLUME_W-1:0] vol_ext;
	logic [SB-1:0]    smp_v, v_q, m1_q;
	logic             usable, full, acc_smp, last_q;
	logic [AW-1:0]    pos_q, half;
	logic [CW-1:0]    cnt_q;
	logic [SUMW-1:0]  sum_q;
	logic             ovf_q, empty_q;
	logic             ram_we;
	logic [AW-1:0]    ram_waddr, ram_raddr;
	logic [SB-1:0]    ram_wdata, ram_rdata;
	logic [SB:0]      twice_med;
	logic             div_start, div_done;
	logic [RATIO_W-1:0] div_ratio;
	logic             res_valid_q, res_load;
	logic [RATIO_W-1:0] ratio_q;
	logic             empty_out_q, ovf_out_q;

	assign vol_ext = {{SB{1'b0}}, smp.volume};
	assign smp_v   = vol_ext[SB-1:0];
	assign usable  = !smp.missing && (smp_v != '0);
	assign full    = (cnt_q == CW'(WINDOW_DEPTH));
	assign acc_smp = smp.valid && smp.ready;
	assign half    = AW'(cnt_q >> 1);
	assign res_load = (state_q == ST_FIN) && (!res_valid_q || res.ready);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (acc_smp) begin
					if (usable && !full) state_d = ST_INS_RD;
					else if (smp.last)   state_d = ST_MED_A;
				end
			end
			ST_INS_RD: begin
				if (pos_q == '0) state_d = last_q ? ST_MED_A : ST_IDLE;
				else             state_d = ST_INS_CMP;
			end
			ST_INS_CMP: begin
				if (ram_rdata > v_q) state_d = ST_INS_RD;
				else                 state_d = last_q ? ST_MED_A : ST_IDLE;
			end
			ST_MED_A: state_d = (cnt_q == '0) ? ST_FIN : ST_MED_B;
			ST_MED_B: state_d = ST_MED_C;
			ST_MED_C: state_d = ST_CALC;
			ST_CALC:  if (div_done) state_d = ST_FIN;
			ST_FIN:   if (res_load) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		smp.ready = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = pos_q;
		ram_wdata = v_q;
		ram_raddr = pos_q - 1'b1;
		div_start = 1'b0;
		case (state_q)
			ST_IDLE:   smp.ready = 1'b1;
			ST_INS_RD: if (pos_q == '0) ram_we = 1'b1;
			ST_INS_CMP: begin
				ram_we = 1'b1;
				// larger neighbor moves up one slot
				if (ram_rdata > v_q) ram_wdata = ram_rdata;
			end
			ST_MED_A:  ram_raddr = half;
			ST_MED_B:  ram_raddr = half - 1'b1;
			ST_MED_C:  div_start = 1'b1;
			default: ;
		endcase
	end

	assign twice_med = cnt_q[0] ? {m1_q, 1'b0} : ({1'b0, m1_q} + {1'b0, ram_rdata});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			sum_q       <= '0;
			ovf_q       <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (acc_smp && usable) begin
				if (full) ovf_q <= 1'b1;
				else      sum_q <= sum_q + SUMW'(smp_v);
			end
			if ((state_q == ST_INS_RD && pos_q == '0) ||
			    (state_q == ST_INS_CMP && !(ram_rdata > v_q))) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (res_load) begin
				cnt_q <= '0;
				sum_q <= '0;
				ovf_q <= 1'b0;
			end
			if (res_load)                   res_valid_q <= 1'b1;
			else if (res.ready)             res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc_smp) begin
			v_q    <= smp_v;
			last_q <= smp.last;
			pos_q  <= AW'(cnt_q);
		end
		if (state_q == ST_INS_CMP && ram_rdata > v_q) begin
			pos_q <= pos_q - 1'b1;
		end
		if (state_q == ST_MED_A) empty_q <= (cnt_q == '0);
		if (state_q == ST_MED_B) m1_q <= ram_rdata;
		if (res_load) begin
			ratio_q     <= empty_q ? '0 : div_ratio;
			empty_out_q <= empty_q;
			ovf_out_q   <= ovf_q;
		end
	end

	wmr_ram #(.WIDTH(SB), .DEPTH(MD)) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	wmr_div #(.SB(SB), .CW(CW)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.twice_med (twice_med),
		.cnt       (cnt_q),
		.sum       (sum_q),
		.done      (div_done),
		.ratio     (div_ratio)
	);

	assign res.valid      = res_valid_q;
	assign res.ratio      = ratio_q;
	assign res.empty_res  = empty_out_q;
	assign res.overflowed = ovf_out_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(WINDOW_DEPTH)) else $error("kept count beyond depth");
	a_done_calc: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_CALC) else $error("divider done outside calc");
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.empty_res |-> res.ratio == '0 && !res.overflowed)
		else $error("empty result with ratio or overflow");
	a_ratio_max: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> res.ratio <= RATIO_MAX) else $error("ratio above two");
	a_ins_write: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_INS_CMP |=> $past(ram_we)) else $error("insert step without write");
endmodule
`default_nettype wire

@@ tb/wmr_tb_if.sv @@
`timescale 1ns / 1ps
// the channel interfaces come with the block (wmr_smp_if, wmr_res_if); nothing to add here
package wmr_tb_pkg;
	localparam int DEPTH = 256;
endpackage

@@ tb/wmr_ratio_checker.sv @@
`timescale 1ns / 1ps
module wmr_ratio_checker (
	input wire logic clk,
	input wire logic arst_n,
	wmr_smp_if smp,
	wmr_res_if res,
	output int fail_count,
	output int ratios_pending,
	output int windows_seen
);
	import wmr_pkg::*;

	typedef struct packed {
		logic [RATIO_W-1:0] ratio;
		logic               empty_res;
		logic               overflowed;
	} ratio_res_t;

	logic [31:0] sorted_vols [$];
	logic [39:0] vol_sum;
	logic        dropped;
	ratio_res_t  ratio_q [$];

	function automatic logic [RATIO_W-1:0] median_ratio();
		int unsigned n;
		logic [63:0] twice_med, num, den, q, r;
		n = sorted_vols.size();
		if (n % 2)
			twice_med = {31'd0, sorted_vols[n/2], 1'b0};
		else
			twice_med = 64'(sorted_vols[n/2]) + 64'(sorted_vols[n/2-1]);
		num = twice_med * 64'(n);
		den = 64'(vol_sum) << 1;
		q = num / den;
		r = num % den;
		for (int i = 0; i < Q_BITS; i++) begin
			r = r << 1;
			q = q << 1;
			if (r >= den) begin
				r = r - den;
				q[0] = 1'b1;
			end
			if (q > 64'(RATIO_MAX))
				return RATIO_MAX;
		end
		return q[RATIO_W-1:0];
	endfunction

	task automatic take_sample(input logic [31:0] v, input logic miss, input logic lst);
		ratio_res_t e;
		int pos;
		if (!miss && v != 0) begin
			if (sorted_vols.size() < wmr_tb_pkg::DEPTH) begin
				pos = sorted_vols.size();
				while (pos > 0 && sorted_vols[pos-1] > v)
					pos--;
				sorted_vols.insert(pos, v);
				vol_sum += 40'(v);
			end else begin
				dropped = 1'b1;
			end
		end
		if (lst) begin
			e.empty_res = sorted_vols.size() == 0;
			e.ratio = e.empty_res ? '0 : median_ratio();
			e.overflowed = dropped;
			ratio_q = {ratio_q, e};
			sorted_vols.delete();
			vol_sum = '0;
			dropped = 1'b0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		ratio_res_t e;
		if (!arst_n) begin
			sorted_vols.delete();
			ratio_q.delete();
			vol_sum = '0;
			dropped = 1'b0;
			fail_count = 0;
			windows_seen = 0;
		end else begin
			if (res.valid && res.ready) begin
				if (ratio_q.size() == 0) begin
					$error("unexpected result transaction ratio=%0d", res.ratio);
					fail_count++;
				end else begin
					e = ratio_q.pop_front();
					windows_seen++;
					if (res.ratio !== e.ratio) begin
						$error("ratio expected %0d actual %0d", e.ratio, res.ratio);
						fail_count++;
					end
					if (res.empty_res !== e.empty_res) begin
						$error("empty_res expected %0b actual %0b", e.empty_res,
							res.empty_res);
						fail_count++;
					end
					if (res.overflowed !== e.overflowed) begin
						$error("overflowed expected %0b actual %0b", e.overflowed,
							res.overflowed);
						fail_count++;
					end
				end
			end
			if (smp.valid && smp.ready)
				take_sample(smp.volume, smp.missing, smp.last);
		end
		ratios_pending = ratio_q.size();
	end
endmodule

@@ tb/tb_window_median_to_mean_ratio.sv @@
`timescale 1ns / 1ps
module tb_window_median_to_mean_ratio;
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int fail_count, ratios_pending, windows_seen;
	int cycles = 0;
	int hold_off = 0;
	int items_sent = 0;

	wmr_smp_if smp ();
	wmr_res_if res ();

	window_median_to_mean_ratio uut (.clk(clk), .arst_n(arst_n), .smp(smp), .res(res));
	wmr_ratio_checker chk (.clk(clk), .arst_n(arst_n), .smp(smp), .res(res),
		.fail_count(fail_count), .ratios_pending(ratios_pending),
		.windows_seen(windows_seen));

	initial begin
		smp.valid = 1'b0;
		smp.volume = '0;
		smp.missing = 1'b0;
		smp.last = 1'b0;
		res.ready = 1'b0;
	end

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 3000000) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 55) return 0;
		if (p < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// receiver: random stalls, plus one long hold-off to fill the block
	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off > 0) begin
				res.ready <= 1'b0;
				hold_off--;
			end else if ($urandom_range(0, 3) == 0) begin
				res.ready <= 1'b0;
			end else begin
				res.ready <= 1'b1;
			end
		end
	end

	task automatic send(input logic [31:0] v, input logic miss, input logic lst);
		int g;
		g = gap_len();
		repeat (g) begin
			smp.valid <= 1'b0;
			@(posedge clk);
		end
		smp.valid <= 1'b1;
		smp.volume <= v;
		smp.missing <= miss;
		smp.last <= lst;
		@(posedge clk);
		while (!smp.ready) @(posedge clk);
		items_sent++;
	endtask

	function automatic logic [31:0] rand_vol(input int mode);
		case (mode)
			0: return $urandom_range(1, 20);
			1: return $urandom;
			2: return 32'hFFFFFFFF - $urandom_range(0, 15);
			default: return $urandom_range(1000, 1100);
		endcase
	endfunction

	initial begin
		int n, mode;
		logic [31:0] v;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: empty windows, single sample, extremes, odd and even counts
		send(32'd0, 1'b0, 1'b1);
		send(32'd5, 1'b1, 1'b1);
		send(32'hFFFFFFFF, 1'b0, 1'b1);
		send(32'd1, 1'b0, 1'b0);
		send(32'hFFFFFFFF, 1'b0, 1'b1);
		send(32'd1, 1'b0, 1'b0);
		send(32'd1, 1'b0, 1'b0);
		send(32'hFFFFFFFF, 1'b0, 1'b1);
		send(32'd7, 1'b0, 1'b0);
		send(32'd0, 1'b0, 1'b0);
		send(32'd3, 1'b1, 1'b0);
		send(32'd9, 1'b0, 1'b0);
		send(32'd2, 1'b0, 1'b1);
		send(32'hAAAAAAAA, 1'b0, 1'b0);
		send(32'h55555555, 1'b0, 1'b1);
		// store overflow: depth plus a few, descending to stress the insertion sort
		for (int i = 0; i < 260; i++)
			send(32'(1000 - i), 1'b0, i == 259);
		// long receiver hold-off while samples keep coming
		hold_off = 400;
		// random windows, mostly short
		while (items_sent < 1850) begin
			n = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
			mode = $urandom_range(0, 3);
			for (int i = 0; i < n; i++) begin
				v = ($urandom_range(0, 9) == 0) ? 32'd0 : rand_vol(mode);
				send(v, $urandom_range(0, 7) == 0, i == n - 1);
			end
		end
		smp.valid <= 1'b0;
		@(posedge clk);
		while (ratios_pending != 0) @(posedge clk);
		repeat (600) @(posedge clk);
		$display("sent %0d sample transactions, checked %0d window results", items_sent,
			windows_seen);
		$display("covered empty, overflowed, odd/even and extreme-volume windows");
		if (fail_count == 0 && ratios_pending == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule

@@ window_median_to_mean_ratio.f @@
hw/rtl/wmr_pkg.sv
hw/rtl/wmr_if.sv
hw/rtl/wmr_ram.sv
hw/rtl/wmr_div.sv
hw/rtl/window_median_to_mean_ratio.sv
tb/wmr_tb_if.sv
tb/wmr_ratio_checker.sv
tb/tb_window_median_to_mean_ratio.sv
